/* sv/hpq_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Heap priority queue package
// Shared request and response types, codes and the priority compare.
// ----------------------------------------------------------------------------
package hpq_pkg;

  // Width of one stored value and of the reported entry count.
  localparam int VALUE_W = 32;
  localparam int COUNT_W = 7;

  typedef logic signed [VALUE_W-1:0] value_t;

  typedef enum logic {
    OP_PUSH = 1'b0,
    OP_POP  = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_POP_EMPTY = 2'd1,
    ST_PUSH_FULL = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    MODE_MAX_FIRST = 2'd0,
    MODE_MIN_FIRST = 2'd1
  } mode_code_t;

  typedef struct packed {
    op_t    op;
    value_t in_value;
  } in_req_t;

  typedef struct packed {
    value_t               top_value;
    logic [COUNT_W-1:0]   entry_count;
    logic                 is_empty;
    status_t              status;
  } out_rsp_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_UP_RD,
    S_UP_CMP,
    S_POP_RD,
    S_POP_LD,
    S_DN_RD,
    S_DN_CMP,
    S_FIN,
    S_DONE
  } hpq_state_t;

  // True when a must sit strictly above b in the heap.
  function automatic logic higher(input value_t a, input value_t b, input logic min_first);
    logic res;
    if (min_first) begin
      res = (a < b);
    end else begin
      res = (a > b);
    end
    return res;
  endfunction

endpackage

/* sv/binary_heap_priority_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Binary heap priority queue
// Push and pop requests on a heap kept in one RAM, one response per request.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid, in_stall, in_req) carries one request: a push
//   of in_value or a pop of the top entry. Every request returns exactly one
//   response on the output channel (out_valid, out_stall, out_rsp) with the
//   top entry, the entry count, an empty flag and a status code.
//   A request is processed one heap level at a time: each level takes a RAM
//   read state and a compare/write state. A push that climbs to the root, or
//   one into an empty queue, ends with a final write state; a pop first
//   reads the last entry and loads it as the item to sink from the root, then
//   sinks until a leaf or a compare stops it. A rejected request, or a pop
//   that empties the queue, goes straight to its response. The next request
//   is taken in the cycle after the response is registered. The longest
//   requests are a push climbing six levels or a pop sinking five in a
//   64-entry queue.
//   The response sits in an output register; a stalled receiver holds it
//   there while the next request is already being processed, and the block
//   waits only if a second response is ready before the first is taken.
//   cfg_we/cfg_data set the order mode (0 largest first, 1 smallest first);
//   the write only takes effect while the queue is empty.
//   Synchronous reset empties the queue, selects largest first and drops any
//   pending response. The heap RAM itself is not cleared.
// ----------------------------------------------------------------------------
module binary_heap_priority_queue #(
  parameter int CAPACITY = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  hpq_pkg::in_req_t  in_req,
  output logic              out_valid,
  input  logic              out_stall,
  output hpq_pkg::out_rsp_t out_rsp,
  input  logic              cfg_we,
  input  logic              cfg_data
);
  import hpq_pkg::*;

  localparam int AW = $clog2(CAPACITY);

  logic          rsp_valid;
  logic          rsp_ready;
  out_rsp_t      rsp;
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  value_t        ram_wdata;
  logic [AW-1:0] ram_raddr_a;
  logic [AW-1:0] ram_raddr_b;
  value_t        ram_rdata_a;
  value_t        ram_rdata_b;

  logic          out_valid_r, out_valid_nxt;
  out_rsp_t      out_rsp_r, out_rsp_nxt;

  // Heap storage.
  hpq_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (ram_waddr),
    .wdata   (ram_wdata),
    .raddr_a (ram_raddr_a),
    .raddr_b (ram_raddr_b),
    .rdata_a (ram_rdata_a),
    .rdata_b (ram_rdata_b)
  );

  // Sift sequencer.
  hpq_ctrl #(
    .CAPACITY (CAPACITY)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_req      (in_req),
    .cfg_we      (cfg_we),
    .cfg_data    (cfg_data),
    .rsp_valid   (rsp_valid),
    .rsp_ready   (rsp_ready),
    .rsp         (rsp),
    .ram_we      (ram_we),
    .ram_waddr   (ram_waddr),
    .ram_wdata   (ram_wdata),
    .ram_raddr_a (ram_raddr_a),
    .ram_raddr_b (ram_raddr_b),
    .ram_rdata_a (ram_rdata_a),
    .ram_rdata_b (ram_rdata_b)
  );

  // Output register: loads when empty or when the held response leaves.
  assign rsp_ready = !out_valid_r || !out_stall;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_rsp_nxt   = out_rsp_r;
    if (rsp_valid && rsp_ready) begin
      out_valid_nxt = 1'b1;
      out_rsp_nxt   = rsp;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_rsp_r <= out_rsp_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_rsp   = out_rsp_r;

endmodule

/* sv/hpq_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and two read ports, read data registered.
// ----------------------------------------------------------------------------
module hpq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_a_r;
  logic [WIDTH-1:0] rdata_b_r;

  // Write port and registered reads.
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_a_r <= mem_r[raddr_a];
    rdata_b_r <= mem_r[raddr_b];
  end

  assign rdata_a = rdata_a_r;
  assign rdata_b = rdata_b_r;

endmodule

/* sv/hpq_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Heap priority queue sequencer
// Runs sift-up and sift-down one level at a time against the heap RAM.
// ----------------------------------------------------------------------------
module hpq_ctrl #(
  parameter int CAPACITY = 64
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  hpq_pkg::in_req_t            in_req,
  input  logic                        cfg_we,
  input  logic                        cfg_data,
  output logic                        rsp_valid,
  input  logic                        rsp_ready,
  output hpq_pkg::out_rsp_t           rsp,
  output logic                        ram_we,
  output logic [$clog2(CAPACITY)-1:0] ram_waddr,
  output hpq_pkg::value_t             ram_wdata,
  output logic [$clog2(CAPACITY)-1:0] ram_raddr_a,
  output logic [$clog2(CAPACITY)-1:0] ram_raddr_b,
  input  hpq_pkg::value_t             ram_rdata_a,
  input  hpq_pkg::value_t             ram_rdata_b
);
  import hpq_pkg::*;

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int XW = AW + 2;

  hpq_state_t     state_r, state_nxt;
  logic [AW-1:0]  idx_r, idx_nxt;
  logic [CW-1:0]  cnt_r, cnt_nxt;
  value_t         item_r, item_nxt;
  value_t         top_r, top_nxt;
  status_t        status_r, status_nxt;
  logic           mode_r;

  logic           accept;
  logic           is_full;
  logic [AW-1:0]  parent;
  logic [XW-1:0]  child_l;
  logic [XW-1:0]  child_r;
  logic           left_ok;
  logic           right_ok;
  logic           pick_right;
  value_t         child_val;
  logic [AW-1:0]  child_idx;

  // Heap address arithmetic for the current level.
  assign accept     = in_valid && (state_r == S_IDLE);
  assign is_full    = (cnt_r == CW'(CAPACITY));
  assign parent     = (idx_r - AW'(1)) >> 1;
  assign child_l    = XW'({idx_r, 1'b1});
  assign child_r    = child_l + XW'(1);
  assign left_ok    = (child_l < XW'(cnt_r));
  assign right_ok   = (child_r < XW'(cnt_r));
  assign pick_right = right_ok && higher(ram_rdata_b, ram_rdata_a, mode_r);
  assign child_val  = pick_right ? ram_rdata_b : ram_rdata_a;
  assign child_idx  = pick_right ? child_r[AW-1:0] : child_l[AW-1:0];

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_req.op == OP_PUSH) begin
            if (is_full) begin
              state_nxt = S_DONE;
            end else if (cnt_r == '0) begin
              state_nxt = S_FIN;
            end else begin
              state_nxt = S_UP_RD;
            end
          end else begin
            if (cnt_r == '0 || cnt_r == CW'(1)) begin
              state_nxt = S_DONE;
            end else begin
              state_nxt = S_POP_RD;
            end
          end
        end
      end
      S_UP_RD: begin
        state_nxt = S_UP_CMP;
      end
      S_UP_CMP: begin
        if (higher(item_r, ram_rdata_a, mode_r)) begin
          state_nxt = (parent == '0) ? S_FIN : S_UP_RD;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_POP_RD: begin
        state_nxt = S_POP_LD;
      end
      S_POP_LD: begin
        state_nxt = S_DN_RD;
      end
      S_DN_RD: begin
        state_nxt = left_ok ? S_DN_CMP : S_DONE;
      end
      S_DN_CMP: begin
        state_nxt = higher(child_val, item_r, mode_r) ? S_DN_RD : S_DONE;
      end
      S_FIN: begin
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (rsp_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Datapath control and register updates for each state.
  always_comb begin
    idx_nxt     = idx_r;
    cnt_nxt     = cnt_r;
    item_nxt    = item_r;
    status_nxt  = status_r;
    ram_we      = 1'b0;
    ram_waddr   = idx_r;
    ram_wdata   = item_r;
    ram_raddr_a = parent;
    ram_raddr_b = child_r[AW-1:0];
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          status_nxt = ST_OK;
          if (in_req.op == OP_PUSH) begin
            if (is_full) begin
              status_nxt = ST_PUSH_FULL;
            end else begin
              item_nxt = in_req.in_value;
              idx_nxt  = cnt_r[AW-1:0];
              cnt_nxt  = cnt_r + CW'(1);
            end
          end else begin
            if (cnt_r == '0) begin
              status_nxt = ST_POP_EMPTY;
            end else begin
              cnt_nxt = cnt_r - CW'(1);
            end
          end
        end
      end
      S_UP_RD: begin
        ram_raddr_a = parent;
      end
      S_UP_CMP: begin
        ram_we = 1'b1;
        if (higher(item_r, ram_rdata_a, mode_r)) begin
          ram_wdata = ram_rdata_a;
          idx_nxt   = parent;
        end
      end
      S_POP_RD: begin
        // The count already points one past the new last entry.
        ram_raddr_a = cnt_r[AW-1:0];
      end
      S_POP_LD: begin
        item_nxt = ram_rdata_a;
        idx_nxt  = '0;
      end
      S_DN_RD: begin
        ram_raddr_a = child_l[AW-1:0];
        ram_raddr_b = child_r[AW-1:0];
        if (!left_ok) begin
          ram_we = 1'b1;
        end
      end
      S_DN_CMP: begin
        ram_we = 1'b1;
        if (higher(child_val, item_r, mode_r)) begin
          ram_wdata = child_val;
          idx_nxt   = child_idx;
        end
      end
      S_FIN: begin
        ram_we = 1'b1;
      end
      S_DONE: begin
        ram_we = 1'b0;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  // The root entry is mirrored so the top is available without a read.
  always_comb begin
    top_nxt = top_r;
    if (ram_we && ram_waddr == '0) begin
      top_nxt = ram_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      mode_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      // Order mode only changes while the queue is empty.
      if (cfg_we && cnt_r == '0) begin
        mode_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx_r    <= idx_nxt;
    item_r   <= item_nxt;
    top_r    <= top_nxt;
    status_r <= status_nxt;
  end

  // Response assembled from the settled state.
  assign in_stall         = (state_r != S_IDLE);
  assign rsp_valid        = (state_r == S_DONE);
  assign rsp.top_value    = (cnt_r == '0) ? '0 : top_r;
  assign rsp.entry_count  = COUNT_W'(cnt_r);
  assign rsp.is_empty     = (cnt_r == '0);
  assign rsp.status       = status_r;

endmodule

/* sv/hpq_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Heap priority queue checker
// Port-level properties of the queue, attached to the top level by bind.
// ----------------------------------------------------------------------------
module hpq_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input hpq_pkg::out_rsp_t out_rsp
);
  import hpq_pkg::*;

  // A held response must not move or vanish while stalled.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_rsp))
    else $error("stalled response changed");

  // Every accepted request moves the sequencer out of idle, so the input stalls in the cycle after an acceptance.
  a_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("request accepted on two consecutive cycles");

  // An empty queue reports no entries and a zero top.
  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_rsp.is_empty |-> out_rsp.entry_count == '0 && out_rsp.top_value == '0)
    else $error("empty response with entries or a nonzero top");

  // A rejected pop can only be reported by an empty queue.
  a_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_rsp.status == ST_POP_EMPTY |-> out_rsp.is_empty)
    else $error("pop rejected while entries are held");

  // Reset drops any pending response.
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("response valid after reset");

endmodule

bind binary_heap_priority_queue hpq_checker u_hpq_checker (.*);

/* bench/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the binary heap priority queue
// Drives push and pop requests and order mode writes, keeps a shadow heap of
// its own, and checks each response field by field against it. Both channels
// idle and stall at random, and the receiver holds off for one long stretch
// so that the block fills up and stalls its input.
// ----------------------------------------------------------------------------
module testbench;
  import hpq_pkg::*;

  localparam int CAP         = 64;
  localparam int IDLE_PCT    = 22;
  localparam int HOLD_CYCLES = 300;
  localparam int WATCH_LIMIT = 2000;
  localparam int NUM_PHASES  = 8;

  // Shadow of the heap contents and mode, with the responses still awaited.
  class heap_scoreboard;
    value_t      entries[CAP];
    int unsigned fill;
    logic        min_first;
    out_rsp_t    awaited_rsps[$];
    int unsigned errors;

    function new();
      fill      = 0;
      min_first = 1'b0;
      errors    = 0;
    endfunction

    // True when a belongs strictly above b under the current order.
    function bit outranks(value_t a, value_t b);
      return min_first ? (a < b) : (a > b);
    endfunction

    // The mode only changes while the queue is empty.
    function void note_mode(logic m);
      if (fill == 0) begin
        min_first = m;
      end
    endfunction

    function void note_request(in_req_t req);
      out_rsp_t    rsp;
      value_t      item;
      int unsigned idx;
      int unsigned kid;
      rsp.status = ST_OK;
      if (req.op == OP_PUSH) begin
        if (fill >= CAP) begin
          rsp.status = ST_PUSH_FULL;
        end else begin
          // Append at the end and move up past weaker parents.
          item = req.in_value;
          idx  = fill;
          while (idx > 0) begin
            if (!outranks(item, entries[(idx - 1) / 2])) break;
            entries[idx] = entries[(idx - 1) / 2];
            idx = (idx - 1) / 2;
          end
          entries[idx] = item;
          fill++;
        end
      end else begin
        if (fill == 0) begin
          rsp.status = ST_POP_EMPTY;
        end else begin
          // Move the last entry to the root and sink it below stronger children.
          fill--;
          item = entries[fill];
          idx  = 0;
          if (fill > 0) begin
            forever begin
              kid = 2 * idx + 1;
              if (kid >= fill) break;
              if (kid + 1 < fill && outranks(entries[kid + 1], entries[kid])) kid++;
              if (!outranks(entries[kid], item)) break;
              entries[idx] = entries[kid];
              idx = kid;
            end
            entries[idx] = item;
          end
        end
      end
      rsp.top_value   = (fill != 0) ? entries[0] : '0;
      rsp.entry_count = fill[COUNT_W-1:0];
      rsp.is_empty    = (fill == 0);
      awaited_rsps    = {awaited_rsps, rsp};
    endfunction

    function void report_field(string name, logic [VALUE_W-1:0] want,
                               logic [VALUE_W-1:0] got);
      if (want !== got) begin
        $display("%0t ns: %s expected %h, got %h", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_response(out_rsp_t got);
      out_rsp_t want;
      if (awaited_rsps.size() == 0) begin
        $display("%0t ns: response with none awaited, expected nothing, got %h",
                 $time, got);
        errors++;
      end else begin
        want = awaited_rsps.pop_front();
        report_field("top_value", want.top_value, got.top_value);
        report_field("entry_count", want.entry_count, got.entry_count);
        report_field("is_empty", want.is_empty, got.is_empty);
        report_field("status", want.status, got.status);
      end
    endfunction

    function int pending();
      return awaited_rsps.size();
    endfunction
  endclass

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_req_t   in_req;
  logic      out_valid;
  logic      out_stall;
  out_rsp_t  out_rsp;
  logic      cfg_we;
  logic      cfg_data;

  heap_scoreboard sb;
  bit             quiet;
  bit             hold_request;
  int             hold_left;
  int             watch_count;

  binary_heap_priority_queue #(.CAPACITY(CAP)) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_rsp   (out_rsp),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data)
  );

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  // Values lean toward the extremes and a narrow band so that ties occur.
  function automatic value_t pick_value();
    case ($urandom_range(9))
      0: return {1'b0, {(VALUE_W-1){1'b1}}};
      1: return {1'b1, {(VALUE_W-1){1'b0}}};
      2: return '0;
      3: return '1;
      4, 5: return value_t'(int'($urandom_range(15)) - 8);
      default: return value_t'($urandom);
    endcase
  endfunction

  // Offer one request from the falling edge on and wait until it is taken.
  task automatic send_request(op_t op, value_t value);
    in_req_t req;
    req.op       = op;
    req.in_value = value;
    while (!quiet && $urandom_range(99) < IDLE_PCT) begin
      in_valid = 1'b0;
      in_req   = in_req_t'({$urandom, $urandom});
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_req   = req;
    forever begin
      @(posedge clk);
      if (!in_stall) break;
    end
    sb.note_request(req);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid = 1'b0;
    while (sb.pending() != 0) begin
      @(negedge clk);
    end
  endtask

  // Write the order mode while the block is idle.
  task automatic write_mode(mode_code_t mode);
    wait_drained();
    cfg_we   = 1'b1;
    cfg_data = mode[0];
    @(negedge clk);
    cfg_we = 1'b0;
    sb.note_mode(mode[0]);
  endtask

  // Receiver: random stalls, a quiet stretch, and one long hold-off on request.
  initial begin
    bit hold_done;
    hold_done = 1'b0;
    out_stall = 1'b0;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_request && !hold_done) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_stall = 1'b1;
        hold_left--;
      end else begin
        out_stall = !quiet && ($urandom_range(99) < IDLE_PCT);
      end
    end
  end

  // Responses are taken at the rising edge.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      sb.check_response(out_rsp);
    end
  end

  // Watchdog on cycles in which neither channel moves a request or response.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      watch_count <= 0;
    end else if (watch_count >= WATCH_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      watch_count <= watch_count + 1;
    end
  end

  initial begin
    int push_pct[NUM_PHASES];
    int phase_len[NUM_PHASES];
    int p;
    int k;

    push_pct     = '{85, 20, 50, 95, 10, 60, 90, 5};
    phase_len    = '{55, 45, 50, 80, 60, 40, 60, 50};
    sb           = new();
    quiet        = 1'b0;
    hold_request = 1'b0;
    in_valid     = 1'b0;
    in_req       = '0;
    cfg_we       = 1'b0;
    cfg_data     = 1'b0;
    rst_n        = 1'b0;
    repeat (4) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Directed: pop on empty, extremes and ties under largest first.
    send_request(OP_POP, '1);
    send_request(OP_PUSH, '0);
    send_request(OP_PUSH, {1'b0, {(VALUE_W-1){1'b1}}});
    send_request(OP_PUSH, {1'b1, {(VALUE_W-1){1'b0}}});
    send_request(OP_PUSH, '1);
    send_request(OP_PUSH, value_t'(1));
    send_request(OP_PUSH, {1'b0, {(VALUE_W-1){1'b1}}});
    send_request(OP_POP, '0);
    send_request(OP_POP, '0);
    send_request(OP_POP, '0);

    // A mode write while entries are held must be ignored.
    write_mode(MODE_MIN_FIRST);
    send_request(OP_PUSH, {1'b1, {(VALUE_W-1){1'b0}}});
    repeat (5) send_request(OP_POP, '0);

    // Smallest first on an empty queue takes effect.
    write_mode(MODE_MIN_FIRST);
    send_request(OP_PUSH, value_t'(5));
    send_request(OP_PUSH, {1'b0, {(VALUE_W-1){1'b1}}});
    send_request(OP_PUSH, {1'b1, {(VALUE_W-1){1'b0}}});
    send_request(OP_PUSH, value_t'(5));
    send_request(OP_POP, '1);
    send_request(OP_POP, '1);
    send_request(OP_POP, '1);
    send_request(OP_POP, '1);
    write_mode(MODE_MAX_FIRST);

    // Random phases: each has its own push mix; a fill-heavy phase runs the
    // queue into full, a drain-heavy one past empty.
    for (p = 0; p < NUM_PHASES; p++) begin
      write_mode($urandom_range(1) ? MODE_MIN_FIRST : MODE_MAX_FIRST);
      quiet = (p == 2);
      if (p == 3) begin
        hold_request = 1'b1;
      end
      for (k = 0; k < phase_len[p]; k++) begin
        if ($urandom_range(99) < push_pct[p]) begin
          send_request(OP_PUSH, pick_value());
        end else begin
          send_request(OP_POP, value_t'($urandom));
        end
      end
    end

    quiet = 1'b0;
    wait_drained();
    repeat (40) @(negedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

/* files.f */
sv/hpq_pkg.sv
sv/hpq_ram.sv
sv/hpq_ctrl.sv
sv/binary_heap_priority_queue.sv
sv/hpq_checker.sv
bench/testbench.sv
